// ===== sv/pfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants for the page framebuffer draw and flush core.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PIXEL = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_FLUSH = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_CMD,
        ST_DATA_RD,
        ST_DATA_CAP,
        ST_DATA_EMIT
    } state_t;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [3:0] CMD_BYTES     = 4'd4;

    localparam logic REG_WRITE_RAM_CMD = 1'b0;

    typedef struct packed {
        logic        is_command;
        logic [3:0]  byte_count;
        logic [63:0] payload;
        logic        last;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/pfb_store.sv =====
// ----------------------------------------------------------------------------
// pfb_store
// Pixel store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_store #(
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]                    rdata,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [7:0]               wdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/pfb_regs.sv =====
// ----------------------------------------------------------------------------
// pfb_regs
// APB-style configuration register holding the write-RAM command byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [7:0]       write_ram_cmd
);
    import pfb_pkg::*;

    logic [7:0] cmd_reg;
    logic [7:0] cmd_next;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_WRITE_RAM_CMD);

    always_comb
    begin
        cmd_next = wr_hit ? pwdata[7:0] : cmd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= 8'h00;
        end
        else
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign prdata        = (paddr[2] == REG_WRITE_RAM_CMD) ? {24'h000000, cmd_reg} : 32'h0;
    assign write_ram_cmd = cmd_reg;

endmodule

`default_nettype wire

// ===== sv/pfb_out_reg.sv =====
// ----------------------------------------------------------------------------
// pfb_out_reg
// Output register that holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire pfb_pkg::out_item_t  item,
    output logic                     free,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pfb_pkg::out_item_t       out_item
);
    import pfb_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== sv/pfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfb_ctrl
// Sequencer: clearing sweeps, read-modify-write of pixel bytes, page flushes.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_ctrl #(
    parameter int PANEL_WIDTH  = pfb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = pfb_pkg::DEF_PANEL_HEIGHT,
    localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8,
    localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT,
    localparam int AW          = $clog2(STORE_BYTES)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          action,
    input  wire logic [7:0]          x,
    input  wire logic [7:0]          y,
    input  wire logic [7:0]          rect_width,
    input  wire logic [7:0]          rect_height,
    input  wire logic                color,
    input  wire logic [2:0]          page,
    input  wire logic [7:0]          write_ram_cmd,
    output logic                     mem_rd_en,
    output logic [AW-1:0]            mem_rd_addr,
    input  wire logic [7:0]          mem_rdata,
    output logic                     mem_wr_en,
    output logic [AW-1:0]            mem_wr_addr,
    output logic [7:0]               mem_wdata,
    input  wire logic                out_free,
    output logic                     out_load,
    output pfb_pkg::out_item_t       out_item
);
    import pfb_pkg::*;

    localparam int COL_W = $clog2(PANEL_WIDTH + 1);
    localparam int PG_W  = $clog2(PAGE_COUNT + 1);
    localparam logic [8:0] WIDTH_9  = 9'(PANEL_WIDTH);
    localparam logic [8:0] HEIGHT_9 = 9'(PANEL_HEIGHT);
    localparam logic [5:0] PAGES_6  = 6'(PAGE_COUNT);

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  col_last_reg, col_last_next;
    logic [PG_W-1:0]   pg_reg, pg_next;
    logic [PG_W-1:0]   pg_first_reg, pg_first_next;
    logic [PG_W-1:0]   pg_last_reg, pg_last_next;
    logic [2:0]        lo_bit_reg, lo_bit_next;
    logic [2:0]        hi_bit_reg, hi_bit_next;
    logic              color_reg, color_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [63:0]       word_reg, word_next;

    logic [8:0]        w_eff, h_eff;
    logic [8:0]        xe_sum, ye_sum, xe, ye;
    logic [8:0]        col_end, row_end;
    logic              area_ok;
    logic [AW:0]       addr_sum;
    logic [AW-1:0]     addr_calc;
    logic [2:0]        lo, hi;
    logic [7:0]        mask;
    logic              word_done;
    logic              flush_last;

    always_comb
    begin
        w_eff   = (action_t'(action) == ACT_PIXEL) ? 9'd1 : {1'b0, rect_width};
        h_eff   = (action_t'(action) == ACT_PIXEL) ? 9'd1 : {1'b0, rect_height};
        xe_sum  = {1'b0, x} + w_eff;
        ye_sum  = {1'b0, y} + h_eff;
        xe      = (xe_sum > WIDTH_9) ? WIDTH_9 : xe_sum;
        ye      = (ye_sum > HEIGHT_9) ? HEIGHT_9 : ye_sum;
        col_end = xe - 9'd1;
        row_end = ye - 9'd1;
        area_ok = ({1'b0, x} < xe) && ({1'b0, y} < ye);

        addr_sum  = (AW + 1)'(pg_reg) * (AW + 1)'(PANEL_WIDTH) + (AW + 1)'(col_reg);
        addr_calc = addr_sum[AW-1:0];

        lo   = (pg_reg == pg_first_reg) ? lo_bit_reg : 3'd0;
        hi   = (pg_reg == pg_last_reg) ? hi_bit_reg : 3'd7;
        mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));

        word_done  = (cnt_reg[2:0] == 3'd7) || (col_reg == COL_W'(PANEL_WIDTH - 1));
        flush_last = (col_reg == COL_W'(PANEL_WIDTH));
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        col_next      = col_reg;
        col_last_next = col_last_reg;
        pg_next       = pg_reg;
        pg_first_next = pg_first_reg;
        pg_last_next  = pg_last_reg;
        lo_bit_next   = lo_bit_reg;
        hi_bit_next   = hi_bit_reg;
        color_next    = color_reg;
        cnt_next      = cnt_reg;
        word_next     = word_reg;

        in_ready    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_calc;
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_calc;
        mem_wdata   = color_reg ? (mem_rdata | mask) : (mem_rdata & ~mask);
        out_load    = 1'b0;
        out_item    = '{is_command: 1'b0, byte_count: cnt_reg, payload: word_reg,
                        last: flush_last};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wdata   = 8'h00;
                if (clr_reg == AW'(STORE_BYTES - 1))
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        ACT_PIXEL, ACT_FILL:
                        begin
                            col_next      = COL_W'(x);
                            col_last_next = COL_W'(col_end);
                            pg_next       = PG_W'(y >> 3);
                            pg_first_next = PG_W'(y >> 3);
                            pg_last_next  = PG_W'(row_end >> 3);
                            lo_bit_next   = y[2:0];
                            hi_bit_next   = row_end[2:0];
                            color_next    = color;
                            if (area_ok)
                            begin
                                state_next = ST_FILL_RD;
                            end
                        end
                        ACT_FLUSH:
                        begin
                            pg_next = PG_W'(page);
                            if ({3'b000, page} < PAGES_6)
                            begin
                                state_next = ST_CMD;
                            end
                        end
                    endcase
                end
            end

            ST_FILL_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_FILL_WR;
            end

            ST_FILL_WR:
            begin
                mem_wr_en  = 1'b1;
                state_next = ST_FILL_RD;
                if (pg_reg == pg_last_reg)
                begin
                    pg_next = pg_first_reg;
                    if (col_reg == col_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                else
                begin
                    pg_next = pg_reg + PG_W'(1);
                end
            end

            ST_CMD:
            begin
                out_item = '{is_command: 1'b1, byte_count: CMD_BYTES,
                             payload: {32'h0, write_ram_cmd, CMD_COL_HIGH, CMD_COL_LOW,
                                       CMD_PAGE_BASE | 8'(pg_reg)},
                             last: 1'b0};
                if (out_free)
                begin
                    out_load   = 1'b1;
                    col_next   = '0;
                    cnt_next   = '0;
                    word_next  = '0;
                    state_next = ST_DATA_RD;
                end
            end

            ST_DATA_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_DATA_CAP;
            end

            ST_DATA_CAP:
            begin
                word_next[{cnt_reg[2:0], 3'b000} +: 8] = mem_rdata;
                cnt_next   = cnt_reg + 4'd1;
                col_next   = col_reg + COL_W'(1);
                state_next = word_done ? ST_DATA_EMIT : ST_DATA_RD;
            end

            ST_DATA_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    cnt_next   = '0;
                    word_next  = '0;
                    state_next = flush_last ? ST_IDLE : ST_DATA_RD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        col_last_reg <= col_last_next;
        pg_reg       <= pg_next;
        pg_first_reg <= pg_first_next;
        pg_last_reg  <= pg_last_next;
        lo_bit_reg   <= lo_bit_next;
        hi_bit_reg   <= hi_bit_next;
        color_reg    <= color_next;
        cnt_reg      <= cnt_next;
        word_reg     <= word_next;
    end

endmodule

`default_nettype wire

// ===== sv/page_framebuffer_draw_flush_core.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_draw_flush_core
// Page-organized monochrome framebuffer with clear, pixel, fill and flush.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Carries
//  in        in_valid / in_ready   action, x, y, rect_width, rect_height, color, page
//  out       out_valid / out_ready is_command, byte_count, payload, last
//  cfg       APB psel / penable    write_ram_command at address 0
//
// A pixel draw or a fill reads and then writes each byte touched, as each
// byte is a read and a write on the single store port pair.
// A clear, and the clearing pass after reset, write zero to all
// PANEL_WIDTH * pages store bytes (1024 by default), with no item accepted.
// A flush emits a command item and then the page's bytes in items of up to
// eight, and stalls while the output register is held by out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_draw_flush_core #(
    parameter int PANEL_WIDTH  = pfb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = pfb_pkg::DEF_PANEL_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  x,
    input  wire logic [7:0]  y,
    input  wire logic [7:0]  rect_width,
    input  wire logic [7:0]  rect_height,
    input  wire logic        color,
    input  wire logic [2:0]  page,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             is_command,
    output logic [3:0]       byte_count,
    output logic [63:0]      payload,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pfb_pkg::*;

    localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(STORE_BYTES);

    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rdata;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    write_ram_cmd;
    logic          out_free;
    logic          out_load;
    out_item_t     load_item;
    out_item_t     held_item;

    pfb_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .write_ram_cmd (write_ram_cmd)
    );

    pfb_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rdata   (mem_rdata),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wdata   (mem_wdata)
    );

    pfb_ctrl #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .x             (x),
        .y             (y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .color         (color),
        .page          (page),
        .write_ram_cmd (write_ram_cmd),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rdata     (mem_rdata),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wdata     (mem_wdata),
        .out_free      (out_free),
        .out_load      (out_load),
        .out_item      (load_item)
    );

    pfb_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .item      (load_item),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (held_item)
    );

    assign is_command = held_item.is_command;
    assign byte_count = held_item.byte_count;
    assign payload    = held_item.payload;
    assign last       = held_item.last;

endmodule

`default_nettype wire
